>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every rising edge outside reset
`define NDW_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// cond must never be true at a rising edge outside reset
`define NDW_ASSERT_NEVER(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define NDW_ASSERT(label, ck, rn, prop, msg)
`define NDW_ASSERT_NEVER(label, ck, rn, cond, msg)
`endif

`endif

>>> rtl/ndw_pkg.sv
// ----------------------------------------------------------------------------
// ndw_pkg
// Widths, register codes and shared structs of the array index walker.
// ----------------------------------------------------------------------------
package ndw_pkg;

    localparam int NUM_AXES       = 4;
    localparam int AXIS_BITS      = $clog2(NUM_AXES);
    localparam int LEN_BITS       = 12;
    localparam int LENX_BITS      = LEN_BITS + 1;
    localparam int RANK_BITS      = 3;
    localparam int S1_BITS        = 2 * LEN_BITS;
    localparam int STRIDE_BITS    = 36;
    localparam int OFFSET_BITS    = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = LEN_BITS;

    // derived geometry runs three multiply stages behind the registers
    localparam int SETTLE_CYCLES  = 3;
    localparam int SETTLE_BITS    = 2;

    localparam logic [RANK_BITS-1:0] RANK_RESET     = RANK_BITS'(0);
    localparam logic [RANK_BITS-1:0] COLLAPSE_RESET = RANK_BITS'(4);
    localparam logic [LEN_BITS-1:0]  LEN_ONE        = LEN_BITS'(1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RANK     = 3'd0,
        REG_LEN_0    = 3'd1,
        REG_LEN_1    = 3'd2,
        REG_LEN_2    = 3'd3,
        REG_LEN_3    = 3'd4,
        REG_COLLAPSE = 3'd5
    } reg_index_t;

    // geometry as seen by the walk and the offset datapath
    typedef struct packed {
        logic                               settled;
        logic                               zero_walk;
        logic [NUM_AXES-1:0]                incl;
        logic [NUM_AXES-1:0][LEN_BITS-1:0]  len;
        logic [LEN_BITS-1:0]                stride_2;
        logic [S1_BITS-1:0]                 stride_1;
        logic [STRIDE_BITS-1:0]             stride_0;
        logic [OFFSET_BITS-1:0]             total;
        logic [LEN_BITS-1:0]                dlen;
        logic [STRIDE_BITS-1:0]             dstr;
    } geom_t;

    // first pipeline stage: walk position after the transfer
    typedef struct packed {
        logic                               valid;
        logic                               elem_valid;
        logic [NUM_AXES-1:0][LEN_BITS-1:0]  pos;
    } walk_t;

endpackage

>>> rtl/ndw_cmd_if.sv
// ----------------------------------------------------------------------------
// ndw_cmd_if
// Command channel: one restart/advance tick per transfer.
// ----------------------------------------------------------------------------
interface ndw_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

>>> rtl/ndw_res_if.sv
// ----------------------------------------------------------------------------
// ndw_res_if
// Result channel: one element offset and walk geometry per transfer.
// ----------------------------------------------------------------------------
interface ndw_res_if;
    import ndw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] offset;
    logic                   elem_valid;
    logic                   last_elem;
    logic [OFFSET_BITS-1:0] total_count;
    logic [LEN_BITS-1:0]    dropped_len;
    logic [STRIDE_BITS-1:0] dropped_stride;

    modport source (output valid, output offset, output elem_valid, output last_elem,
                    output total_count, output dropped_len, output dropped_stride,
                    input ready);
    modport sink   (input valid, input offset, input elem_valid, input last_elem,
                    input total_count, input dropped_len, input dropped_stride,
                    output ready);
endinterface

>>> rtl/ndw_geom.sv
// ----------------------------------------------------------------------------
// ndw_geom
// Configuration registers and pipelined stride / element count products.
// ----------------------------------------------------------------------------
module ndw_geom (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [ndw_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [ndw_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output ndw_pkg::geom_t                     geom
);
    import ndw_pkg::*;

    logic [RANK_BITS-1:0]               rank_reg;
    logic [RANK_BITS-1:0]               collapse_reg;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  len_reg;
    logic [SETTLE_BITS-1:0]             settle_reg;

    logic [RANK_BITS-1:0]               eff_rank;
    logic                               has_k;
    logic [NUM_AXES-1:0]                in_rank;
    logic [NUM_AXES-1:0]                incl;
    logic                               zero_walk;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  le;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  lc;
    logic [LEN_BITS-1:0]                dlen;
    logic [STRIDE_BITS-1:0]             dstr_next;

    logic [S1_BITS-1:0]                 stride_1_reg;
    logic [S1_BITS-1:0]                 part_23_reg;
    logic [STRIDE_BITS-1:0]             stride_0_reg;
    logic [STRIDE_BITS-1:0]             part_123_reg;
    logic [OFFSET_BITS-1:0]             total_reg;
    logic [STRIDE_BITS-1:0]             dstr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= RANK_RESET;
            collapse_reg <= COLLAPSE_RESET;
            len_reg      <= {NUM_AXES{LEN_ONE}};
            settle_reg   <= SETTLE_BITS'(SETTLE_CYCLES);
        end
        else if (wr_en)
        begin
            settle_reg <= SETTLE_BITS'(SETTLE_CYCLES);
            unique case (wr_index)
                REG_RANK:     rank_reg     <= wr_data[RANK_BITS-1:0];
                REG_LEN_0:    len_reg[0]   <= wr_data;
                REG_LEN_1:    len_reg[1]   <= wr_data;
                REG_LEN_2:    len_reg[2]   <= wr_data;
                REG_LEN_3:    len_reg[3]   <= wr_data;
                REG_COLLAPSE: collapse_reg <= wr_data[RANK_BITS-1:0];
                default:      ;
            endcase
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    always_comb
    begin
        eff_rank  = (rank_reg > RANK_BITS'(NUM_AXES)) ? RANK_BITS'(NUM_AXES) : rank_reg;
        has_k     = collapse_reg < eff_rank;
        zero_walk = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            in_rank[i] = RANK_BITS'(i) < eff_rank;
            incl[i]    = in_rank[i] && (collapse_reg != RANK_BITS'(i));
            le[i]      = in_rank[i] ? len_reg[i] : LEN_ONE;
            // collapsed axis counts as 1, or 0 when its length is 0
            if (!in_rank[i])
                lc[i] = LEN_ONE;
            else if (incl[i])
                lc[i] = len_reg[i];
            else
                lc[i] = (len_reg[i] != '0) ? LEN_ONE : '0;
            if (in_rank[i] && (len_reg[i] == '0))
                zero_walk = 1'b1;
        end
        dlen = has_k ? len_reg[collapse_reg[AXIS_BITS-1:0]] : '0;
        dstr_next = '0;
        if (has_k)
        begin
            unique case (collapse_reg[AXIS_BITS-1:0])
                2'd0:    dstr_next = stride_0_reg;
                2'd1:    dstr_next = STRIDE_BITS'(stride_1_reg);
                2'd2:    dstr_next = STRIDE_BITS'(le[3]);
                default: dstr_next = STRIDE_BITS'(1);
            endcase
        end
    end

    // one multiply per stage
    always_ff @(posedge clk)
    begin
        stride_1_reg <= S1_BITS'(le[2]) * S1_BITS'(le[3]);
        part_23_reg  <= S1_BITS'(lc[2]) * S1_BITS'(lc[3]);
        stride_0_reg <= STRIDE_BITS'(stride_1_reg) * STRIDE_BITS'(le[1]);
        part_123_reg <= STRIDE_BITS'(part_23_reg) * STRIDE_BITS'(lc[1]);
        total_reg    <= OFFSET_BITS'(part_123_reg) * OFFSET_BITS'(lc[0]);
        dstr_reg     <= dstr_next;
    end

    assign geom.settled   = (settle_reg == '0);
    assign geom.zero_walk = zero_walk;
    assign geom.incl      = incl;
    assign geom.len       = len_reg;
    assign geom.stride_2  = le[3];
    assign geom.stride_1  = stride_1_reg;
    assign geom.stride_0  = stride_0_reg;
    assign geom.total     = total_reg;
    assign geom.dlen      = dlen;
    assign geom.dstr      = dstr_reg;

endmodule

>>> rtl/ndw_step.sv
// ----------------------------------------------------------------------------
// ndw_step
// Walk position counters with carry chain; first pipeline register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndw_step (
    input  logic           clk,
    input  logic           rst_n,
    input  ndw_pkg::geom_t geom,
    ndw_cmd_if.sink        cmd,
    input  logic           take,
    output ndw_pkg::walk_t walk
);
    import ndw_pkg::*;

    logic [NUM_AXES-1:0][LEN_BITS-1:0]  pos_reg;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  pos_next;
    logic                               active_reg;
    logic                               active_next;
    logic                               v1_reg;
    logic                               ev1_reg;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  pos1_reg;

    logic                               accept;
    logic                               carry;
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  adv_pos;
    logic [NUM_AXES-1:0][LENX_BITS-1:0] inc;

    assign cmd.ready = geom.settled && (!v1_reg || take);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            inc[i] = LENX_BITS'(pos_reg[i]) + LENX_BITS'(1);
        // ripple from the fastest axis; skipped axes pass the carry
        carry   = 1'b1;
        adv_pos = pos_reg;
        for (int a = NUM_AXES - 1; a >= 0; a--)
        begin
            if (!geom.zero_walk && geom.incl[a] && carry)
            begin
                if (inc[a] < LENX_BITS'(geom.len[a]))
                begin
                    adv_pos[a] = inc[a][LEN_BITS-1:0];
                    carry      = 1'b0;
                end
                else
                begin
                    adv_pos[a] = '0;
                end
            end
        end

        pos_next    = pos_reg;
        active_next = active_reg;
        if (cmd.restart)
        begin
            pos_next    = '0;
            active_next = !geom.zero_walk;
        end
        else if (active_reg)
        begin
            pos_next = adv_pos;
            if (carry)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
            v1_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg    <= pos_next;
                active_reg <= active_next;
            end
            if (accept)
                v1_reg <= 1'b1;
            else if (take)
                v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev1_reg  <= active_next;
            pos1_reg <= pos_next;
        end
    end

    assign walk.valid      = v1_reg;
    assign walk.elem_valid = ev1_reg;
    assign walk.pos        = pos1_reg;

    `NDW_ASSERT(a_restart_active, clk, rst_n, accept && cmd.restart |=> active_reg == !$past(geom.zero_walk), "restart did not set walk state from geometry")
    `NDW_ASSERT(a_idle_advance, clk, rst_n, accept && !cmd.restart && !active_reg |=> walk.valid && !walk.elem_valid, "advance without a walk gave an element")
    `NDW_ASSERT(a_state_hold, clk, rst_n, !accept |=> $stable(pos_reg) && $stable(active_reg), "walk state moved without a transfer")

endmodule

>>> rtl/ndw_offset.sv
// ----------------------------------------------------------------------------
// ndw_offset
// Per-axis stride products, offset sum and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndw_offset (
    input  logic           clk,
    input  logic           rst_n,
    input  ndw_pkg::geom_t geom,
    input  ndw_pkg::walk_t walk,
    output logic           take,
    ndw_res_if.source      result
);
    import ndw_pkg::*;

    logic [NUM_AXES-1:0][LEN_BITS-1:0]    m;
    logic [NUM_AXES-1:0][OFFSET_BITS-1:0] prod_next;
    logic                                 last_next;
    logic                                 en3;

    logic                                 v2_reg;
    logic [NUM_AXES-1:0][OFFSET_BITS-1:0] prod_reg;
    logic                                 ev2_reg;
    logic                                 last2_reg;

    logic                                 out_valid_reg;
    logic [OFFSET_BITS-1:0]               offset_reg;
    logic                                 ev_reg;
    logic                                 last_reg;
    logic [OFFSET_BITS-1:0]               total_reg;
    logic [LEN_BITS-1:0]                  dlen_reg;
    logic [STRIDE_BITS-1:0]               dstr_reg;

    assign en3  = !out_valid_reg || result.ready;
    assign take = !v2_reg || en3;

    always_comb
    begin
        last_next = walk.elem_valid;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m[i] = (walk.elem_valid && geom.incl[i]) ? walk.pos[i] : '0;
            if (geom.incl[i] &&
                (LENX_BITS'(walk.pos[i]) + LENX_BITS'(1) < LENX_BITS'(geom.len[i])))
                last_next = 1'b0;
        end
        prod_next[0] = OFFSET_BITS'(m[0]) * OFFSET_BITS'(geom.stride_0);
        prod_next[1] = OFFSET_BITS'(m[1]) * OFFSET_BITS'(geom.stride_1);
        prod_next[2] = OFFSET_BITS'(m[2]) * OFFSET_BITS'(geom.stride_2);
        prod_next[3] = OFFSET_BITS'(m[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                v2_reg <= walk.valid;
            if (en3)
                out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && walk.valid)
        begin
            prod_reg  <= prod_next;
            ev2_reg   <= walk.elem_valid;
            last2_reg <= last_next;
        end
        if (en3 && v2_reg)
        begin
            offset_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
            ev_reg     <= ev2_reg;
            last_reg   <= last2_reg;
            total_reg  <= geom.total;
            dlen_reg   <= geom.dlen;
            dstr_reg   <= geom.dstr;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.offset         = offset_reg;
    assign result.elem_valid     = ev_reg;
    assign result.last_elem      = last_reg;
    assign result.total_count    = total_reg;
    assign result.dropped_len    = dlen_reg;
    assign result.dropped_stride = dstr_reg;

    `NDW_ASSERT_NEVER(a_invalid_clean, clk, rst_n, result.valid && !result.elem_valid && (result.offset != '0 || result.last_elem), "non-element result carries offset or last")
    `NDW_ASSERT(a_stage_hold, clk, rst_n, v2_reg && !en3 |=> v2_reg, "product stage dropped while result stalled")
    `NDW_ASSERT(a_last_is_elem, clk, rst_n, result.valid && result.last_elem |-> result.elem_valid, "last flag on a non-element result")

endmodule

>>> rtl/nd_array_index_walker_unit.sv
// ----------------------------------------------------------------------------
// nd_array_index_walker_unit
// Row-major address generator for arrays of up to four axes.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : valid/ready channel, one transfer per tick. restart=1 begins a
//            walk at position zero and returns its first element, restart=0
//            advances one element of the current walk.
//   result : valid/ready channel, one transfer per command transfer, in
//            order: offset, elem_valid, last_elem, total_count, dropped_len,
//            dropped_stride.
//   wr_*   : register write port (rank, four axis lengths, collapse axis);
//            write only while no command is in flight.
// A command transfer passes the stage 1, product and result registers
// before result valid; throughput is one transfer per cycle while the
// result side accepts and the geometry is settled. The position carry
// chain across the four axis counters closes in the command cycle; stride
// products and the 4-way offset sum take the next two stages. After reset,
// and after every register write, cmd.ready stays low while the three-stage
// stride / count multiply chain refreshes. When the result side stalls, the
// pipeline fills and cmd.ready drops only once every stage holds a result.
// ----------------------------------------------------------------------------
module nd_array_index_walker_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [ndw_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [ndw_pkg::CFG_DATA_BITS-1:0]  wr_data,
    ndw_cmd_if.sink                            cmd,
    ndw_res_if.source                          result
);
    import ndw_pkg::*;

    // geometry: configuration plus derived strides and counts
    geom_t geom;
    // stage 1 contents: position after the transfer
    walk_t walk;
    // product stage can take stage 1 this cycle
    logic  take;

    ndw_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .geom     (geom)
    );

    // walk counters: restart clears, advance ripples a carry from the
    // fastest axis, skipping the collapsed one and axes above the rank
    ndw_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .cmd   (cmd),
        .take  (take),
        .walk  (walk)
    );

    // per-axis products then the offset sum into the result register
    ndw_offset u_offset (
        .clk    (clk),
        .rst_n  (rst_n),
        .geom   (geom),
        .walk   (walk),
        .take   (take),
        .result (result)
    );

endmodule
